// ===== design/psd_pkg.sv =====
// package for point_segment_distance: constants, widths and closest-point kind codes
// used by point_segment_distance and the testbench; no dependencies
package psd_pkg;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned POS_BITS   = 24;
  localparam int unsigned DIST_BITS  = 49;

  typedef enum logic [1:0] {
    KIND_FOOT  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2,
    KIND_ZERO  = 2'd3
  } kind_e;
endpackage

// ===== design/psd_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with stall
// depends on nothing but its parameters
module psd_div #(
  parameter int unsigned NumBits = 42,
  parameter int unsigned DenBits = 34,
  parameter int unsigned TagBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  input  logic [TagBits-1:0] tag_i,
  output logic               valid_o,
  output logic [NumBits-1:0] quo_o,
  output logic [TagBits-1:0] tag_o
);
  localparam int unsigned RemBits = DenBits + 1;

  logic               v_q   [NumBits+1];
  logic [NumBits-1:0] n_q   [NumBits+1];
  logic [RemBits-1:0] r_q   [NumBits+1];
  logic [DenBits-1:0] d_q   [NumBits+1];
  logic [TagBits-1:0] t_q   [NumBits+1];

  always_comb begin
    v_q[0] = valid_i;
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    t_q[0] = tag_i;
  end

  for (genvar g = 0; g < NumBits; g++) begin : g_stage
    logic [RemBits-1:0] sh;
    logic [RemBits:0]   diff;
    logic               vs_q;
    logic [NumBits-1:0] ns_q;
    logic [RemBits-1:0] rs_q;
    logic [DenBits-1:0] ds_q;
    logic [TagBits-1:0] ts_q;
    assign sh   = {r_q[g][RemBits-2:0], n_q[g][NumBits-1]};
    assign diff = {1'b0, sh} - {2'b00, d_q[g]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q <= 1'b0;
      end else if (en_i) begin
        vs_q <= v_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (diff[RemBits]) begin
          rs_q <= sh;
          ns_q <= {n_q[g][NumBits-2:0], 1'b0};
        end else begin
          rs_q <= diff[RemBits-1:0];
          ns_q <= {n_q[g][NumBits-2:0], 1'b1};
        end
        ds_q <= d_q[g];
        ts_q <= t_q[g];
      end
    end
    always_comb begin
      v_q[g+1] = vs_q;
      n_q[g+1] = ns_q;
      r_q[g+1] = rs_q;
      d_q[g+1] = ds_q;
      t_q[g+1] = ts_q;
    end
  end

  assign valid_o = v_q[NumBits];
  assign quo_o   = n_q[NumBits];
  assign tag_o   = t_q[NumBits];
endmodule

// ===== design/point_segment_distance.sv =====
// point_segment_distance top level: front end, divider pipeline, distance back end
// depends on psd_pkg and psd_div
//
// Usage: one input word (query point and segment endpoints) enters on the
// in channel each cycle that in_valid_i is high and in_stall_o is low. One
// result word (closest point, squared distance, kind) leaves on the out
// channel when out_valid_o is high and out_stall_i is low.
// Throughput is one word per cycle while the output is not stalled.
// Between in and out lie four front-end stages, the bit-serial divide
// pipeline that rounds the foot offset, one quotient bit per stage, and
// three back-end stages.
// The whole pipeline advances together; when out_stall_i holds a valid
// result every stage freezes, empty ones too, and in_stall_o rises, so
// nothing is lost or repeated.
// Reset clears all valid bits; the block holds no state between words.
module point_segment_distance #(
  parameter int unsigned COORD_BITS = psd_pkg::COORD_BITS,
  parameter int unsigned FRAC_BITS  = psd_pkg::FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic signed [COORD_BITS-1:0]        seg_start_x_i,
  input  logic signed [COORD_BITS-1:0]        seg_start_y_i,
  input  logic signed [COORD_BITS-1:0]        seg_end_x_i,
  input  logic signed [COORD_BITS-1:0]        seg_end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] closest_x_o,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] closest_y_o,
  output logic [2*(COORD_BITS+FRAC_BITS):0]   squared_distance_o,
  output logic [1:0]                          closest_kind_o
);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DB  = CB + 1;          // difference width
  localparam int unsigned MB  = DB - 1;          // magnitude of difference
  localparam int unsigned L2B = 2 * MB + 1;      // len2 and |dot| width
  localparam int unsigned NB  = MB + L2B + FRAC_BITS + 1; // 2*num
  localparam int unsigned DNB = L2B + 1;         // 2*len2
  localparam int unsigned PB  = CB + FRAC_BITS;
  localparam int unsigned PDB = PB + 1;
  localparam int unsigned SQB = 2 * PB + 1;
  // tag: sx, sy, px, py, ex, ey, kind, sign x, sign y
  localparam int unsigned TB  = 6 * CB + 2 + 2;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: differences
  logic              v1_q;
  logic signed [DB-1:0] dx1_q, dy1_q, qx1_q, qy1_q;
  logic signed [CB-1:0] px1_q, py1_q, sx1_q, sy1_q, ex1_q, ey1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= DB'(seg_end_x_i) - DB'(seg_start_x_i);
      dy1_q <= DB'(seg_end_y_i) - DB'(seg_start_y_i);
      qx1_q <= DB'(point_x_i) - DB'(seg_start_x_i);
      qy1_q <= DB'(point_y_i) - DB'(seg_start_y_i);
      px1_q <= point_x_i;     py1_q <= point_y_i;
      sx1_q <= seg_start_x_i; sy1_q <= seg_start_y_i;
      ex1_q <= seg_end_x_i;   ey1_q <= seg_end_y_i;
    end
  end

  // stage 2: products
  logic v2_q;
  logic signed [2*DB-1:0] ddx2_q, ddy2_q, dtx2_q, dty2_q;
  logic signed [DB-1:0] dx2_q, dy2_q;
  logic signed [CB-1:0] px2_q, py2_q, sx2_q, sy2_q, ex2_q, ey2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ddx2_q <= dx1_q * dx1_q; ddy2_q <= dy1_q * dy1_q;
      dtx2_q <= qx1_q * dx1_q; dty2_q <= qy1_q * dy1_q;
      dx2_q <= dx1_q; dy2_q <= dy1_q;
      px2_q <= px1_q; py2_q <= py1_q; sx2_q <= sx1_q; sy2_q <= sy1_q;
      ex2_q <= ex1_q; ey2_q <= ey1_q;
    end
  end

  // stage 3: len2, dot, classify (endpoint compare via signed dot/len2)
  logic v3_q;
  logic [L2B-1:0] len3_q, dot3_q;
  logic [MB-1:0]  mx3_q, my3_q;
  logic [1:0]     kind3_q;
  logic           snx3_q, sny3_q;
  logic signed [CB-1:0] px3_q, py3_q, sx3_q, sy3_q, ex3_q, ey3_q;
  logic signed [2*DB:0] len_s, dot_s, twodot;
  logic [1:0] kind_c;
  always_comb begin
    len_s  = (2*DB+1)'(ddx2_q) + (2*DB+1)'(ddy2_q);
    dot_s  = (2*DB+1)'(dtx2_q) + (2*DB+1)'(dty2_q);
    twodot = dot_s <<< 1;
    // |P-S|^2 <= |P-E|^2  <=>  2 dot <= len2
    if (dx2_q == '0 && dy2_q == '0) kind_c = psd_pkg::KIND_ZERO;
    else if (dot_s >= 0 && dot_s <= len_s) kind_c = psd_pkg::KIND_FOOT;
    else if (twodot <= len_s) kind_c = psd_pkg::KIND_START;
    else kind_c = psd_pkg::KIND_END;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      len3_q  <= (len_s == '0) ? L2B'(1) : len_s[L2B-1:0];
      dot3_q  <= (kind_c == psd_pkg::KIND_FOOT) ? dot_s[L2B-1:0] : '0;
      mx3_q   <= dx2_q[DB-1] ? MB'(-dx2_q) : dx2_q[MB-1:0];
      my3_q   <= dy2_q[DB-1] ? MB'(-dy2_q) : dy2_q[MB-1:0];
      snx3_q  <= dx2_q[DB-1]; sny3_q <= dy2_q[DB-1];
      kind3_q <= kind_c;
      px3_q <= px2_q; py3_q <= py2_q; sx3_q <= sx2_q; sy3_q <= sy2_q;
      ex3_q <= ex2_q; ey3_q <= ey2_q;
    end
  end

  // stage 4: numerators 2*num + len2
  logic v4_q;
  logic [NB-1:0]  nx4_q, ny4_q;
  logic [DNB-1:0] den4_q;
  logic [TB-1:0]  tag4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx4_q  <= ((NB'(mx3_q) * NB'(dot3_q)) << (FRAC_BITS + 1)) + NB'(len3_q);
      ny4_q  <= ((NB'(my3_q) * NB'(dot3_q)) << (FRAC_BITS + 1)) + NB'(len3_q);
      den4_q <= {len3_q, 1'b0};
      tag4_q <= {sx3_q, sy3_q, px3_q, py3_q, ex3_q, ey3_q, kind3_q, snx3_q, sny3_q};
    end
  end

  // the y divider carries the y sign, the x divider the rest of the tag
  logic          vdx, vdy;
  logic [NB-1:0] qx, qy;
  logic [TB-2:0] tgx;
  logic          tgy;
  psd_div #(.NumBits(NB), .DenBits(DNB), .TagBits(TB-1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .num_i(nx4_q), .den_i(den4_q),
    .tag_i(tag4_q[TB-1:1]), .valid_o(vdx), .quo_o(qx), .tag_o(tgx));
  psd_div #(.NumBits(NB), .DenBits(DNB), .TagBits(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .num_i(ny4_q), .den_i(den4_q),
    .tag_i(tag4_q[0]), .valid_o(vdy), .quo_o(qy), .tag_o(tgy));

  // stage 5: closest point
  logic signed [CB-1:0] sx5, sy5, px5, py5, ex5, ey5;
  logic [1:0] k5;
  logic snx5, sny5;
  assign {sx5, sy5, px5, py5, ex5, ey5, k5, snx5} = tgx;
  assign sny5 = tgy;
  logic v5_q;
  logic signed [PB-1:0] cx5_q, cy5_q;
  logic signed [PDB-1:0] ex_d5_q, ey_d5_q;
  logic [1:0] k5_q;
  logic signed [PB-1:0] cx_c, cy_c, ox, oy, pxf, pyf;
  always_comb begin
    ox = snx5 ? -PB'(qx) : PB'(qx);
    oy = sny5 ? -PB'(qy) : PB'(qy);
    pxf = PB'(px5) <<< FRAC_BITS;
    pyf = PB'(py5) <<< FRAC_BITS;
    case (k5)
      psd_pkg::KIND_FOOT: begin
        cx_c = (PB'(sx5) <<< FRAC_BITS) + ox;
        cy_c = (PB'(sy5) <<< FRAC_BITS) + oy;
      end
      psd_pkg::KIND_END: begin
        cx_c = PB'(ex5) <<< FRAC_BITS;
        cy_c = PB'(ey5) <<< FRAC_BITS;
      end
      default: begin
        cx_c = PB'(sx5) <<< FRAC_BITS;
        cy_c = PB'(sy5) <<< FRAC_BITS;
      end
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= vdx && vdy;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx5_q <= cx_c; cy5_q <= cy_c; k5_q <= k5;
      ex_d5_q <= PDB'(cx_c) - PDB'(pxf);
      ey_d5_q <= PDB'(cy_c) - PDB'(pyf);
    end
  end

  // stage 6: squares
  logic v6_q;
  logic signed [PB-1:0] cx6_q, cy6_q;
  logic [1:0] k6_q;
  logic [2*PB-1:0] sqx6_q, sqy6_q;
  logic [PB-1:0] amx, amy;
  assign amx = ex_d5_q[PDB-1] ? PB'(-ex_d5_q) : ex_d5_q[PB-1:0];
  assign amy = ey_d5_q[PDB-1] ? PB'(-ey_d5_q) : ey_d5_q[PB-1:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx6_q <= (2*PB)'(amx) * (2*PB)'(amx);
      sqy6_q <= (2*PB)'(amy) * (2*PB)'(amy);
      cx6_q <= cx5_q; cy6_q <= cy5_q; k6_q <= k5_q;
    end
  end

  // stage 7: output register
  logic v7_q;
  logic signed [PB-1:0] cx7_q, cy7_q;
  logic [SQB-1:0] sq7_q;
  logic [1:0] k7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq7_q <= SQB'(sqx6_q) + SQB'(sqy6_q);
      cx7_q <= cx6_q; cy7_q <= cy6_q; k7_q <= k6_q;
    end
  end

  assign out_valid_o        = v7_q;
  assign closest_x_o        = cx7_q;
  assign closest_y_o        = cy7_q;
  assign squared_distance_o = sq7_q;
  assign closest_kind_o     = k7_q;
endmodule

// ===== test/tb.sv =====
// testbench for point_segment_distance: predicts closest point, squared distance and kind
// for each accepted word and checks the result stream; depends on psd_pkg and the design
`timescale 1ns / 100ps

module tb;
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [48:0]        sq_dist;
    psd_pkg::kind_e     kind;
  } closest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] point_x_i = '0, point_y_i = '0;
  logic signed [15:0] seg_start_x_i = '0, seg_start_y_i = '0;
  logic signed [15:0] seg_end_x_i = '0, seg_end_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] closest_x_o, closest_y_o;
  logic [48:0] squared_distance_o;
  logic [1:0] closest_kind_o;

  closest_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  localparam int WATCHDOG = 20000;

  point_segment_distance DUT (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [63:0] sq64(input longint v);
    return v * v;
  endfunction

  function automatic longint round_offset(input longint d, input longint dot, input longint len2);
    longint unsigned num, q;
    num = ((d < 0 ? -d : d) * dot) << 8;
    q = (2 * num + len2) / (2 * len2);
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic closest_t closest_point(input longint px, py, sx, sy, ex, ey);
    closest_t r;
    longint dx, dy, len2, dot, cx, cy;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) begin
      cx = sx * 256; cy = sy * 256; r.kind = psd_pkg::KIND_ZERO;
    end else begin
      len2 = dx * dx + dy * dy;
      dot = (px - sx) * dx + (py - sy) * dy;
      if (dot >= 0 && dot <= len2) begin
        cx = sx * 256 + round_offset(dx, dot, len2);
        cy = sy * 256 + round_offset(dy, dot, len2);
        r.kind = psd_pkg::KIND_FOOT;
      end else if (sq64(sx - px) + sq64(sy - py) <= sq64(ex - px) + sq64(ey - py)) begin
        cx = sx * 256; cy = sy * 256; r.kind = psd_pkg::KIND_START;
      end else begin
        cx = ex * 256; cy = ey * 256; r.kind = psd_pkg::KIND_END;
      end
    end
    r.cx = 24'(cx);
    r.cy = 24'(cy);
    r.sq_dist = 49'(sq64(cx - px * 256) + sq64(cy - py * 256));
    return r;
  endfunction

  // valid stays high into the next word unless the sender idles
  task automatic send_word(input logic [15:0] px, py, sx, sy, ex, ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= px; point_y_i <= py;
    seg_start_x_i <= sx; seg_start_y_i <= sy;
    seg_end_x_i <= ex; seg_end_y_i <= ey;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(closest_point(signed'(px), signed'(py), signed'(sx), signed'(sy),
                                       signed'(ex), signed'(ey)));
    @(negedge clk_i);
  endtask

  // stall driven at falling edge
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    closest_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) report("result word with nothing expected");
      else begin
        e = expected_q.pop_front();
        if (closest_x_o !== e.cx) report($sformatf("closest_x %h exp %h", closest_x_o, e.cx));
        if (closest_y_o !== e.cy) report($sformatf("closest_y %h exp %h", closest_y_o, e.cy));
        if (squared_distance_o !== e.sq_dist)
          report($sformatf("distance %h exp %h", squared_distance_o, e.sq_dist));
        if (closest_kind_o !== e.kind)
          report($sformatf("kind %0d exp %0d", closest_kind_o, e.kind));
      end
    end
  end

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? 16'(16'h7fff - $urandom_range(3))
                                  : 16'(16'h8000 + $urandom_range(3));
      default: return 16'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic test_directed();
    send_word(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_word(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_word(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_word(16'sd5, 16'sd7, 16'sd3, 16'sd3, 16'sd3, 16'sd3);      // zero-length segment
    send_word(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_word(16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd10, 16'sd0);     // foot on first endpoint
    send_word(16'sd10, -16'sd5, 16'sd0, 16'sd0, 16'sd10, 16'sd0);   // foot on second endpoint
    send_word(16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0);     // interior foot
    send_word(-16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0);    // before start
    send_word(16'sd13, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0);    // past end
    send_word(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0);      // exact third
    send_word(16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd3, 16'sd7);      // rounding
    send_word(-16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd3, -16'sd7);  // negative direction
    send_word(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd512);    // foot on first endpoint of a vertical segment
    send_word(16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd1);
    send_word(-16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd4, 16'sd0);
    send_word(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd32766, 16'sd0);
    send_word(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb);
  endtask

  task automatic test_random(input int count);
    logic [15:0] sx, sy;
    repeat (count) begin
      sx = rnd_coord(); sy = rnd_coord();
      if ($urandom_range(15) == 0) send_word(rnd_coord(), rnd_coord(), sx, sy, sx, sy);
      else send_word(rnd_coord(), rnd_coord(), sx, sy, rnd_coord(), rnd_coord());
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  stall_pct = 0;  test_random(400);
    send_idle_pct = 85; stall_pct = 0;  test_random(300);
    send_idle_pct = 0;  stall_pct = 85; test_random(350);
    send_idle_pct = 37; stall_pct = 37; test_random(380);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_idle_phases();
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== sim.f =====
design/psd_pkg.sv
design/psd_div.sv
design/point_segment_distance.sv
test/tb.sv
